[rtl/fsa_pkg.sv]
package fsa_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    localparam logic [15:0] CAPACITY_RESET = 16'd1000;
    localparam logic [31:0] PLACE_REVENUE  = 32'd10;
    localparam logic [31:0] REVENUE_MAX    = 32'hFFFF_FFFF;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    localparam logic [2:0] ST_PLACED     = 3'd0;
    localparam logic [2:0] ST_NO_FIT     = 3'd1;
    localparam logic [2:0] ST_TABLE_FULL = 3'd2;
    localparam logic [2:0] ST_RELEASED   = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd4;
    localparam logic [2:0] ST_CLEARED    = 3'd5;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] owner_tag;
        logic [15:0] length;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] start_offset;
        logic [31:0] revenue;
    } res_t;

    typedef struct packed {
        logic        used;
        logic [15:0] length;
        logic [15:0] owner;
    } seg_t;

endpackage

[rtl/first_fit_segment_allocator.sv]
// First-fit segment allocator. A word is taken when start is high and busy is low; its
// result appears on result for exactly one cycle with done high and cannot be held off.
// Allocate and release walk the segment table one entry per cycle through a registered
// read of the table memory; a split or merge then moves the entries behind the hit one by
// one, and a split writes the leftover free tail last. The walk and the move together pass
// each live entry about once. Clear, unknown operations and zero-length allocates finish
// in the idle state and never raise busy. A capacity write takes effect at the next clear;
// reset behaves as a clear with capacity 1000 and also zeroes the revenue.
module first_fit_segment_allocator
    import fsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_t        request,
    output logic        done,
    output res_t        result,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_REL_NEXT = 3'd2;
    localparam logic [2:0] S_MOVE     = 3'd3;
    localparam logic [2:0] S_MFLUSH   = 3'd4;
    localparam logic [2:0] S_TAIL     = 3'd5;

    seg_t mem [MAX_SEGMENTS];
    seg_t rdata_reg;
    logic [IDX_W-1:0] rd_addr_reg;

    logic [2:0]       state_reg, state_next;
    req_t             req_reg, req_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [15:0]      pos_reg, pos_next;
    logic             prev_free_reg, prev_free_next;
    logic [15:0]      prev_len_reg, prev_len_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [15:0]      found_len_reg, found_len_next;
    logic [15:0]      off_reg, off_next;
    logic             has_next_reg, has_next_next;
    logic [IDX_W-1:0] mv_src_reg, mv_src_next;
    logic [IDX_W-1:0] mv_last_reg, mv_last_next;
    logic             mv_up_reg, mv_up_next;
    logic [1:0]       mv_gap_reg, mv_gap_next;
    logic             pw_valid_reg, pw_valid_next;
    logic [IDX_W-1:0] pw_addr_reg, pw_addr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      revenue_reg, revenue_next;
    logic [15:0]      capacity_reg;
    logic [15:0]      clear_len_reg, clear_len_next;
    logic             fresh_reg, fresh_next;
    res_t             res_reg, res_next;
    logic             done_reg, done_next;

    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    seg_t             wdata;
    seg_t             ent;

    // entry 0 reads as one free segment of clear_len until it is first written
    always_comb
    begin
        ent = rdata_reg;
        if (fresh_reg && rd_addr_reg == '0)
        begin
            ent.used   = 1'b0;
            ent.length = clear_len_reg;
        end
    end

    always_comb
    begin
        logic             fin;
        logic [2:0]       fin_status;
        logic [15:0]      fin_off;
        logic             fin_place;
        logic [31:0]      rev_sat;
        logic             next_free;
        logic [15:0]      total;
        logic [1:0]       gap;
        logic [CNT_W:0]   d0;
        logic [CNT_W:0]   src0;
        logic             is_alloc;

        fin        = 1'b0;
        fin_status = ST_NO_FIT;
        fin_off    = '0;
        fin_place  = 1'b0;
        next_free  = 1'b0;
        total      = '0;
        gap        = '0;
        d0         = '0;
        src0       = '0;
        is_alloc   = (req_reg.operation == OP_ALLOC);
        rev_sat    = (revenue_reg > REVENUE_MAX - PLACE_REVENUE) ?
                     REVENUE_MAX : revenue_reg + PLACE_REVENUE;

        state_next     = state_reg;
        req_next       = req_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        prev_free_next = prev_free_reg;
        prev_len_next  = prev_len_reg;
        i_next         = i_reg;
        found_len_next = found_len_reg;
        off_next       = off_reg;
        has_next_next  = has_next_reg;
        mv_src_next    = mv_src_reg;
        mv_last_next   = mv_last_reg;
        mv_up_next     = mv_up_reg;
        mv_gap_next    = mv_gap_reg;
        pw_valid_next  = 1'b0;
        pw_addr_next   = pw_addr_reg;
        count_next     = count_reg;
        revenue_next   = revenue_reg;
        clear_len_next = clear_len_reg;
        fresh_next     = fresh_reg;
        res_next       = res_reg;
        done_next      = 1'b0;

        raddr = '0;
        we    = 1'b0;
        waddr = '0;
        wdata = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next       = request;
                    idx_next       = '0;
                    pos_next       = '0;
                    prev_free_next = 1'b0;
                    unique case (request.operation)
                        OP_ALLOC:
                        begin
                            if (request.length == '0)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_NO_FIT;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_RELEASE:
                        begin
                            state_next = S_SCAN;
                        end
                        OP_CLEAR:
                        begin
                            fresh_next     = 1'b1;
                            clear_len_next = capacity_reg;
                            count_next     = CNT_W'(1);
                            fin            = 1'b1;
                            fin_status     = ST_CLEARED;
                        end
                        default:
                        begin
                            fin        = 1'b1;
                            fin_status = ST_NO_FIT;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                raddr = idx_reg[IDX_W-1:0] + IDX_W'(1);
                if (idx_reg >= count_reg)
                begin
                    fin        = 1'b1;
                    fin_status = is_alloc ? ST_NO_FIT : ST_NOT_FOUND;
                end
                else if (is_alloc && !ent.used && ent.length >= req_reg.length)
                begin
                    off_next       = pos_reg;
                    i_next         = idx_reg;
                    found_len_next = ent.length;
                    if (ent.length == req_reg.length)
                    begin
                        we         = 1'b1;
                        waddr      = idx_reg[IDX_W-1:0];
                        wdata      = '{used: 1'b1, length: req_reg.length,
                                       owner: req_reg.owner_tag};
                        fin        = 1'b1;
                        fin_status = ST_PLACED;
                        fin_off    = pos_reg;
                        fin_place  = 1'b1;
                    end
                    else if (count_reg == CNT_W'(MAX_SEGMENTS))
                    begin
                        fin        = 1'b1;
                        fin_status = ST_TABLE_FULL;
                    end
                    else
                    begin
                        we         = 1'b1;
                        waddr      = idx_reg[IDX_W-1:0];
                        wdata      = '{used: 1'b1, length: req_reg.length,
                                       owner: req_reg.owner_tag};
                        count_next = count_reg + CNT_W'(1);
                        if (idx_reg + CNT_W'(1) < count_reg)
                        begin
                            mv_src_next  = IDX_W'(count_reg - CNT_W'(1));
                            mv_last_next = IDX_W'(idx_reg + CNT_W'(1));
                            mv_up_next   = 1'b1;
                            state_next   = S_MOVE;
                        end
                        else
                        begin
                            state_next = S_TAIL;
                        end
                    end
                end
                else if (!is_alloc && ent.used && ent.owner == req_reg.owner_tag)
                begin
                    off_next       = pos_reg;
                    i_next         = idx_reg;
                    found_len_next = ent.length + (prev_free_reg ? prev_len_reg : 16'd0);
                    has_next_next  = (idx_reg + CNT_W'(1) < count_reg);
                    state_next     = S_REL_NEXT;
                end
                else
                begin
                    idx_next       = idx_reg + CNT_W'(1);
                    pos_next       = pos_reg + ent.length;
                    prev_free_next = !ent.used;
                    prev_len_next  = ent.length;
                end
            end

            S_REL_NEXT:
            begin
                next_free  = has_next_reg && !ent.used;
                total      = found_len_reg + (next_free ? ent.length : 16'd0);
                gap        = {1'b0, prev_free_reg} + {1'b0, next_free};
                we         = 1'b1;
                waddr      = prev_free_reg ? IDX_W'(i_reg - CNT_W'(1)) : i_reg[IDX_W-1:0];
                wdata      = '{used: 1'b0, length: total, owner: req_reg.owner_tag};
                count_next = count_reg - CNT_W'(gap);
                d0         = prev_free_reg ? {1'b0, i_reg} : {1'b0, i_reg} + (CNT_W+1)'(1);
                src0       = d0 + (CNT_W+1)'(gap);
                if (gap != 2'd0 && src0 < {1'b0, count_reg})
                begin
                    mv_src_next  = src0[IDX_W-1:0];
                    mv_last_next = IDX_W'(count_reg - CNT_W'(1));
                    mv_up_next   = 1'b0;
                    mv_gap_next  = gap;
                    state_next   = S_MOVE;
                end
                else
                begin
                    fin        = 1'b1;
                    fin_status = ST_RELEASED;
                    fin_off    = off_reg;
                end
            end

            S_MOVE:
            begin
                raddr         = mv_src_reg;
                we            = pw_valid_reg;
                waddr         = pw_addr_reg;
                wdata         = rdata_reg;
                pw_valid_next = 1'b1;
                pw_addr_next  = mv_up_reg ? mv_src_reg + IDX_W'(1)
                                          : mv_src_reg - IDX_W'(mv_gap_reg);
                if (mv_src_reg == mv_last_reg)
                begin
                    state_next = S_MFLUSH;
                end
                else
                begin
                    mv_src_next = mv_up_reg ? mv_src_reg - IDX_W'(1)
                                            : mv_src_reg + IDX_W'(1);
                end
            end

            S_MFLUSH:
            begin
                we    = pw_valid_reg;
                waddr = pw_addr_reg;
                wdata = rdata_reg;
                if (mv_up_reg)
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    fin        = 1'b1;
                    fin_status = ST_RELEASED;
                    fin_off    = off_reg;
                end
            end

            S_TAIL:
            begin
                we         = 1'b1;
                waddr      = IDX_W'(i_reg + CNT_W'(1));
                wdata      = '{used: 1'b0, length: found_len_reg - req_reg.length,
                               owner: req_reg.owner_tag};
                fin        = 1'b1;
                fin_status = ST_PLACED;
                fin_off    = off_reg;
                fin_place  = 1'b1;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (we && waddr == '0)
        begin
            fresh_next = 1'b0;
        end

        if (fin)
        begin
            state_next            = S_IDLE;
            done_next             = 1'b1;
            res_next.status       = fin_status;
            res_next.start_offset = fin_off;
            res_next.revenue      = fin_place ? rev_sat : revenue_reg;
            if (fin_place)
            begin
                revenue_next = rev_sat;
            end
        end
    end

    // table memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg   <= mem[raddr];
        rd_addr_reg <= raddr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pw_valid_reg  <= 1'b0;
            count_reg     <= CNT_W'(1);
            revenue_reg   <= '0;
            capacity_reg  <= CAPACITY_RESET;
            clear_len_reg <= CAPACITY_RESET;
            fresh_reg     <= 1'b1;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pw_valid_reg  <= pw_valid_next;
            count_reg     <= count_next;
            revenue_reg   <= revenue_next;
            clear_len_reg <= clear_len_next;
            fresh_reg     <= fresh_next;
            done_reg      <= done_next;
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        idx_reg       <= idx_next;
        pos_reg       <= pos_next;
        prev_free_reg <= prev_free_next;
        prev_len_reg  <= prev_len_next;
        i_reg         <= i_next;
        found_len_reg <= found_len_next;
        off_reg       <= off_next;
        has_next_reg  <= has_next_next;
        mv_src_reg    <= mv_src_next;
        mv_last_reg   <= mv_last_next;
        mv_up_reg     <= mv_up_next;
        mv_gap_reg    <= mv_gap_next;
        pw_addr_reg   <= pw_addr_next;
        res_reg       <= res_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule
